/* sv/lprc_pkg.sv */
// Shared constants and default settings of the latency PI rate controller.
`timescale 1ns / 1ps
`default_nettype none

package lprc_pkg;

    // Defaults of the top level parameters.
    localparam int RATE_MIN_Q16_DEF = 6554;
    localparam int RATE_MAX_Q16_DEF = 131072;
    localparam int NS_BITS_DEF      = 48;

    // Q16 fixed point.
    localparam int Q16_FRAC = 16;
    localparam int Q16_ONE  = 65536;

    // Field and state widths.
    localparam int GAIN_W     = 19;
    localparam int RATE_W     = 19;
    localparam int RATE_OUT_W = 18;
    localparam int INTEG_W    = 35;
    localparam int ERR_W      = 20;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LATENCY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN     = 2'd2;

    // Register reset values.
    localparam int TARGET_LATENCY_RST = 20000000;
    localparam int PROP_GAIN_RST      = 32768;
    localparam int INTEG_GAIN_RST     = 6554;

    // Input operation codes.
    localparam logic OP_FEEDBACK = 1'b0;
    localparam logic OP_IDLE     = 1'b1;
endpackage

`default_nettype wire

/* sv/latency_pi_rate_controller.sv */
// Latency driven PI pacing controller with integrator anti-windup, Q16 fixed point.
//
// Usage: one input beat carries an operation and a time in nanoseconds. A feedback
// beat (operation 0) carries a measured latency; the block forms the normalized
// error against the target latency, updates the clamped integrator and returns the
// new rate. An idle beat (operation 1) carries elapsed idle time; the rate relaxes
// toward 1.0 by 0.1 per second and the integrator is re-seeded from the remaining gap.
// Every input beat yields exactly one output beat carrying the rate in Q16.
// Only the idle state takes a beat, so the block takes no new beat until the result
// of the last one has moved to the output register. The arithmetic runs on the
// restoring divider, one quotient bit per cycle, and the 19 step shift-and-add
// multiplier. After reset and after each write of the integral gain, the first
// beat also computes the two integrator limits.
// Reset (synchronous, active low) loads the register defaults, sets the rate to 1.0
// and clears the integrator. A configuration write of any listed register does the
// same for rate and integrator. If the receiver stalls, the result waits in the
// output register; the block still takes and works the next beat, and holds its
// result until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module latency_pi_rate_controller
    import lprc_pkg::*;
#(
    parameter int RATE_MIN_Q16 = RATE_MIN_Q16_DEF,
    parameter int RATE_MAX_Q16 = RATE_MAX_Q16_DEF,
    parameter int NS_BITS      = NS_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [NS_BITS-1:0]    i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_operation,
    input  logic [NS_BITS-1:0]    i_value_ns,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [RATE_OUT_W-1:0] o_rate
);

    // Divider: numerator is left aligned in a shift register, one quotient bit per cycle.
    localparam int DIFF_MAG_W = 47;
    localparam int DIV_NUM_W  = DIFF_MAG_W + Q16_FRAC;
    localparam int DIV_Q_W    = INTEG_W;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
    localparam int R_W        = NS_BITS + 1;
    localparam int DW         = (R_W > DIFF_MAG_W) ? R_W : DIFF_MAG_W;
    localparam int LIM_NUM_W  = 34;
    localparam int GAP_MAG_W  = 18;
    localparam int GAP_W      = 21;
    localparam int STEP_W     = 20;

    // Multiplier: two shift-and-add products side by side, one gain bit per cycle.
    localparam int MUL_A_W   = 51;
    localparam int MUL_B_W   = 54;
    localparam int MUL_CNT_W = $clog2(GAIN_W + 1);
    localparam int SUM_W     = MUL_B_W - Q16_FRAC + 2;

    // Idle decay.
    localparam int EL_W      = 37;
    localparam int EL_PROD_W = 50;
    localparam int VW        = (NS_BITS > EL_W) ? NS_BITS : EL_W;
    localparam int DECAY_STEP_Q16 = 6554;
    localparam int NANOS_PER_SEC  = 1000000000;
    localparam logic [EL_W-1:0] ELAPSED_CAP = 37'd100000000000;

    localparam logic [DIFF_MAG_W-1:0] DIFF_LIM = DIFF_MAG_W'(1) << (DIFF_MAG_W - 1);
    localparam logic signed [ERR_W-1:0] ERR_MAX = ERR_W'(Q16_ONE);
    localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

    localparam logic [LIM_NUM_W-1:0] LIM_HI_NUM =
        LIM_NUM_W'(64'(RATE_MAX_Q16 - Q16_ONE) << Q16_FRAC);
    localparam logic [LIM_NUM_W-1:0] LIM_LO_NUM =
        LIM_NUM_W'(64'(Q16_ONE - RATE_MIN_Q16) << Q16_FRAC);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIM_HI,
        S_LIM_LO,
        S_LIM_DONE,
        S_FB_LOAD,
        S_FB_ERR,
        S_FB_SUM,
        S_ID_LOAD,
        S_ID_STEP,
        S_ID_GAP,
        S_ID_INT,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

    // Control and architectural state.
    t_state                     r_state;
    t_state                     r_ret;
    logic [NS_BITS-1:0]         r_target;
    logic [GAIN_W-1:0]          r_kp;
    logic [GAIN_W-1:0]          r_ki;
    logic signed [INTEG_W-1:0]  r_integ;
    logic [RATE_W-1:0]          r_rate;
    logic                       r_lim_ok;
    logic                       r_out_valid;
    logic [RATE_OUT_W-1:0]      r_out_rate;

    // Datapath registers.
    logic                       r_op;
    logic [NS_BITS-1:0]         r_value;
    logic signed [INTEG_W-1:0]  r_lim_hi;
    logic signed [INTEG_W-1:0]  r_lim_lo;
    logic                       r_neg;
    logic [DIV_NUM_W-1:0]       r_num;
    logic [NS_BITS-1:0]         r_den;
    logic [R_W-1:0]             r_rem;
    logic [DIV_Q_W-1:0]         r_quo;
    logic                       r_quo_ovf;
    logic [DIV_CNT_W-1:0]       r_div_cnt;
    logic signed [MUL_A_W-1:0]  r_mcand_a;
    logic signed [MUL_B_W-1:0]  r_mcand_b;
    logic [GAIN_W-1:0]          r_mplier_a;
    logic [GAIN_W-1:0]          r_mplier_b;
    logic signed [MUL_A_W-1:0]  r_acc_a;
    logic signed [MUL_B_W-1:0]  r_acc_b;
    logic [MUL_CNT_W-1:0]       r_mul_cnt;

    // Combinational helpers.
    logic                       in_accept;
    logic [GAIN_W-1:0]          ki_eff;
    logic [NS_BITS-1:0]         t_eff;
    logic [R_W-1:0]             diff;
    logic                       diff_neg;
    logic [R_W-1:0]             diff_mag;
    logic [DW-1:0]              diff_mag_x;
    logic [DIFF_MAG_W-1:0]      diff_clamped;
    logic [R_W-1:0]             div_rem_sh;
    logic                       div_ge;
    logic [R_W-1:0]             div_rem_nx;
    logic [ERR_W-1:0]           err_mag;
    logic                       err_pos_sat;
    logic                       err_neg_sat;
    logic signed [ERR_W-1:0]    err;
    logic signed [INTEG_W:0]    integ_sum;
    logic signed [INTEG_W:0]    lim_hi_x;
    logic signed [INTEG_W:0]    lim_lo_x;
    logic signed [INTEG_W-1:0]  integ_clamped;
    logic signed [SUM_W-1:0]    rate_sum;
    logic [RATE_W-1:0]          rate_fb;
    logic [VW-1:0]              value_x;
    logic [EL_W-1:0]            elapsed;
    logic signed [GAP_W-1:0]    gap;
    logic signed [GAP_W-1:0]    step_x;
    logic signed [GAP_W-1:0]    gap_dec;
    logic [GAP_W-1:0]           gap_abs;
    logic [RATE_W-1:0]          rate_id;

    function automatic logic [RATE_W-1:0] clamp_rate(input logic signed [SUM_W-1:0] v);
        logic [RATE_W-1:0] r;
        if (v < SUM_W'(RATE_MIN_Q16)) begin
            r = RATE_W'(RATE_MIN_Q16);
        end else if (v > SUM_W'(RATE_MAX_Q16)) begin
            r = RATE_W'(RATE_MAX_Q16);
        end else begin
            r = v[RATE_W-1:0];
        end
        return r;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_rate      = r_out_rate;

    // A zero integral gain or zero target behaves as one.
    assign ki_eff = (r_ki == '0) ? GAIN_W'(1) : r_ki;
    assign t_eff  = (r_target == '0) ? NS_BITS'(1) : r_target;

    // Latency difference, split into sign and magnitude, magnitude clamped to 2^46.
    assign diff         = {1'b0, t_eff} - {1'b0, r_value};
    assign diff_neg     = diff[R_W-1];
    assign diff_mag     = diff_neg ? (~diff + 1'b1) : diff;
    assign diff_mag_x   = DW'(diff_mag);
    assign diff_clamped = (diff_mag_x > DW'(DIFF_LIM)) ? DIFF_LIM
                                                       : diff_mag_x[DIFF_MAG_W-1:0];

    // One restoring division step.
    assign div_rem_sh = {r_rem[R_W-2:0], r_num[DIV_NUM_W-1]};
    assign div_ge     = (div_rem_sh >= {1'b0, r_den});
    assign div_rem_nx = div_ge ? (div_rem_sh - {1'b0, r_den}) : div_rem_sh;

    // Error from the truncated quotient, clamped to [-8.0, 1.0].
    assign err_mag     = r_quo[ERR_W-1:0];
    assign err_pos_sat = r_quo_ovf || (r_quo > DIV_Q_W'(ERR_MAX));
    assign err_neg_sat = r_quo_ovf || (r_quo > DIV_Q_W'(1 << (ERR_W - 1)));
    assign err = r_neg ? (err_neg_sat ? ERR_MIN : -err_mag)
                       : (err_pos_sat ? ERR_MAX : err_mag);

    // Integrator update with anti-windup limits.
    assign integ_sum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(err);
    assign lim_hi_x  = (INTEG_W+1)'(r_lim_hi);
    assign lim_lo_x  = (INTEG_W+1)'(r_lim_lo);

    always_comb begin
        if (integ_sum > lim_hi_x) begin
            integ_clamped = r_lim_hi;
        end else if (integ_sum < lim_lo_x) begin
            integ_clamped = r_lim_lo;
        end else begin
            integ_clamped = integ_sum[INTEG_W-1:0];
        end
    end

    // Both products shift right arithmetically, which rounds toward minus infinity.
    assign rate_sum = SUM_W'(Q16_ONE) + SUM_W'(r_acc_a >>> Q16_FRAC)
                    + SUM_W'(r_acc_b >>> Q16_FRAC);
    assign rate_fb  = clamp_rate(rate_sum);

    // Idle time, capped at 100 seconds.
    assign value_x = VW'(r_value);
    assign elapsed = (value_x > VW'(ELAPSED_CAP)) ? ELAPSED_CAP : value_x[EL_W-1:0];

    // Gap to 1.0 shrinks by the decay step without crossing zero.
    assign gap    = $signed({2'b00, r_rate}) - GAP_W'(Q16_ONE);
    assign step_x = $signed({1'b0, r_quo[STEP_W-1:0]});

    always_comb begin
        if (gap > 0) begin
            gap_dec = (gap > step_x) ? (gap - step_x) : '0;
        end else if (gap < 0) begin
            gap_dec = (gap < -step_x) ? (gap + step_x) : '0;
        end else begin
            gap_dec = '0;
        end
    end

    assign gap_abs = gap_dec[GAP_W-1] ? -gap_dec : gap_dec;
    assign rate_id = clamp_rate(SUM_W'(gap_dec) + SUM_W'(Q16_ONE));

    // Sequencer, architectural state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_target    <= NS_BITS'(TARGET_LATENCY_RST);
            r_kp        <= GAIN_W'(PROP_GAIN_RST);
            r_ki        <= GAIN_W'(INTEG_GAIN_RST);
            r_integ     <= '0;
            r_rate      <= RATE_W'(Q16_ONE);
            r_lim_ok    <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_rate  <= '0;
        end else begin
            // A new result enters the output register as soon as it is free; a taken
            // beat otherwise empties it.
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (!r_lim_ok) begin
                            r_state <= S_LIM_HI;
                        end else if (i_operation == OP_IDLE) begin
                            r_state <= S_ID_LOAD;
                        end else begin
                            r_state <= S_FB_LOAD;
                        end
                    end
                end
                S_LIM_HI: begin
                    r_ret   <= S_LIM_LO;
                    r_state <= S_DIV;
                end
                S_LIM_LO: begin
                    r_ret   <= S_LIM_DONE;
                    r_state <= S_DIV;
                end
                S_LIM_DONE: begin
                    r_lim_ok <= 1'b1;
                    r_state  <= (r_op == OP_IDLE) ? S_ID_LOAD : S_FB_LOAD;
                end
                S_FB_LOAD: begin
                    r_ret   <= S_FB_ERR;
                    r_state <= S_DIV;
                end
                S_FB_ERR: begin
                    r_integ <= integ_clamped;
                    r_ret   <= S_FB_SUM;
                    r_state <= S_MUL;
                end
                S_FB_SUM: begin
                    r_rate  <= rate_fb;
                    r_state <= S_OUT;
                end
                S_ID_LOAD: begin
                    r_ret   <= S_ID_STEP;
                    r_state <= S_MUL;
                end
                S_ID_STEP: begin
                    r_ret   <= S_ID_GAP;
                    r_state <= S_DIV;
                end
                S_ID_GAP: begin
                    r_rate  <= rate_id;
                    r_ret   <= S_ID_INT;
                    r_state <= S_DIV;
                end
                S_ID_INT: begin
                    r_integ <= r_neg ? -r_quo : r_quo;
                    r_state <= S_OUT;
                end
                S_DIV: begin
                    if (r_div_cnt == DIV_CNT_W'(1)) begin
                        r_state <= r_ret;
                    end
                end
                S_MUL: begin
                    if (r_mul_cnt == MUL_CNT_W'(1)) begin
                        r_state <= r_ret;
                    end
                end
                S_OUT: begin
                    // The result moves out only when the output register is free.
                    if (!r_out_valid || i_out_ready) begin
                        r_out_rate <= r_rate[RATE_OUT_W-1:0];
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Configuration writes must come only while idle; the block does not check.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET_LATENCY: begin
                        r_target <= i_cfg_data;
                        r_integ  <= '0;
                        r_rate   <= RATE_W'(Q16_ONE);
                    end
                    CFG_PROP_GAIN: begin
                        r_kp    <= i_cfg_data[GAIN_W-1:0];
                        r_integ <= '0;
                        r_rate  <= RATE_W'(Q16_ONE);
                    end
                    CFG_INTEG_GAIN: begin
                        r_ki     <= i_cfg_data[GAIN_W-1:0];
                        r_integ  <= '0;
                        r_rate   <= RATE_W'(Q16_ONE);
                        r_lim_ok <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Divider, multiplier and operand registers; loaded by the sequencer states.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_op    <= i_operation;
                    r_value <= i_value_ns;
                end
            end
            S_LIM_HI: begin
                r_num     <= {LIM_HI_NUM, {(DIV_NUM_W-LIM_NUM_W){1'b0}}};
                r_den     <= NS_BITS'(ki_eff);
                r_div_cnt <= DIV_CNT_W'(LIM_NUM_W);
                r_rem     <= '0;
                r_quo     <= '0;
                r_quo_ovf <= 1'b0;
            end
            S_LIM_LO: begin
                r_lim_hi  <= r_quo;
                r_num     <= {LIM_LO_NUM, {(DIV_NUM_W-LIM_NUM_W){1'b0}}};
                r_den     <= NS_BITS'(ki_eff);
                r_div_cnt <= DIV_CNT_W'(LIM_NUM_W);
                r_rem     <= '0;
                r_quo     <= '0;
                r_quo_ovf <= 1'b0;
            end
            S_LIM_DONE: begin
                r_lim_lo <= -r_quo;
            end
            S_FB_LOAD: begin
                r_neg     <= diff_neg;
                r_num     <= {diff_clamped, {Q16_FRAC{1'b0}}};
                r_den     <= t_eff;
                r_div_cnt <= DIV_CNT_W'(DIV_NUM_W);
                r_rem     <= '0;
                r_quo     <= '0;
                r_quo_ovf <= 1'b0;
            end
            S_FB_ERR: begin
                r_mcand_a  <= MUL_A_W'(err);
                r_mplier_a <= r_kp;
                r_mcand_b  <= MUL_B_W'(integ_clamped);
                r_mplier_b <= ki_eff;
                r_acc_a    <= '0;
                r_acc_b    <= '0;
                r_mul_cnt  <= MUL_CNT_W'(GAIN_W);
            end
            S_ID_LOAD: begin
                r_mcand_a  <= MUL_A_W'(elapsed);
                r_mplier_a <= GAIN_W'(DECAY_STEP_Q16);
                r_mcand_b  <= '0;
                r_mplier_b <= '0;
                r_acc_a    <= '0;
                r_acc_b    <= '0;
                r_mul_cnt  <= MUL_CNT_W'(GAIN_W);
            end
            S_ID_STEP: begin
                r_num     <= {r_acc_a[EL_PROD_W-1:0], {(DIV_NUM_W-EL_PROD_W){1'b0}}};
                r_den     <= NS_BITS'(NANOS_PER_SEC);
                r_div_cnt <= DIV_CNT_W'(EL_PROD_W);
                r_rem     <= '0;
                r_quo     <= '0;
                r_quo_ovf <= 1'b0;
            end
            S_ID_GAP: begin
                r_neg     <= gap_dec[GAP_W-1];
                r_num     <= {gap_abs[GAP_MAG_W-1:0], {Q16_FRAC{1'b0}},
                              {(DIV_NUM_W-LIM_NUM_W){1'b0}}};
                r_den     <= NS_BITS'(ki_eff);
                r_div_cnt <= DIV_CNT_W'(LIM_NUM_W);
                r_rem     <= '0;
                r_quo     <= '0;
                r_quo_ovf <= 1'b0;
            end
            S_DIV: begin
                r_rem     <= div_rem_nx;
                r_quo     <= {r_quo[DIV_Q_W-2:0], div_ge};
                r_quo_ovf <= r_quo_ovf | r_quo[DIV_Q_W-1];
                r_num     <= {r_num[DIV_NUM_W-2:0], 1'b0};
                r_div_cnt <= r_div_cnt - 1'b1;
            end
            S_MUL: begin
                r_acc_a    <= r_acc_a + (r_mplier_a[0] ? r_mcand_a : '0);
                r_acc_b    <= r_acc_b + (r_mplier_b[0] ? r_mcand_b : '0);
                r_mcand_a  <= r_mcand_a <<< 1;
                r_mcand_b  <= r_mcand_b <<< 1;
                r_mplier_a <= r_mplier_a >> 1;
                r_mplier_b <= r_mplier_b >> 1;
                r_mul_cnt  <= r_mul_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/lprc_checker.sv */
// Port level checker of the latency PI rate controller and its bind.
`timescale 1ns / 1ps
`default_nettype none

module lprc_checker
    import lprc_pkg::*;
#(
    parameter int RATE_MIN_Q16 = RATE_MIN_Q16_DEF,
    parameter int RATE_MAX_Q16 = RATE_MAX_Q16_DEF
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  i_in_ready,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [RATE_OUT_W-1:0] i_rate
);

    logic       in_beat;
    logic       out_beat;
    logic [1:0] r_pending;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // Beats taken in but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_beat && !out_beat) begin
            r_pending <= r_pending + 1'b1;
        end else if (out_beat && !in_beat) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rate))
        else $error("output beat changed while stalled");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 2'd0)
        else $error("result without an input beat");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !i_in_ready)
        else $error("input taken again while an item is in work");

    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_rate) >= RATE_MIN_Q16 && int'(i_rate) <= RATE_MAX_Q16)
                     || (int'(i_rate) == RATE_MAX_Q16 - (1 << RATE_OUT_W)))
        else $error("rate outside its limits");

endmodule

bind latency_pi_rate_controller lprc_checker #(
    .RATE_MIN_Q16 (RATE_MIN_Q16),
    .RATE_MAX_Q16 (RATE_MAX_Q16)
) u_lprc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_rate      (o_rate)
);

`default_nettype wire
